// ===== rtl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types, codes, glyph table and sizing helpers for the seven-segment
// digit driver
// ----------------------------------------------------------------------------
package ssd_pkg;

    // fixed field widths
    localparam int VALUE_W   = 16;
    localparam int BASE_W    = 5;
    localparam int DIGIT_W   = 4;
    localparam int SEG_W     = 8;
    localparam int POS_W     = 2;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = BASE_W;

    // register defaults and limits
    localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
    localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;

    // default number of digits in full mode
    localparam int DIGIT_COUNT_DEFAULT = 4;

    // display commands
    localparam logic [CMD_W-1:0] CMD_ONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TWO  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FULL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMMON_ANODE = 1'd1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } ssd_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic             load;   // take a new value, clear remainder
        logic             step;   // one restoring division step
        logic             store;  // final step of a digit, keep remainder
        logic             emit;   // load the output register
        logic             last;   // final digit of this value
        logic [POS_W-1:0] pos;    // digit position to show
    } ssd_ctrl_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;           // output register can take a result
    } ssd_stat_t;

    // digits shown in full mode, kept to 1..4
    function automatic int ssd_full_count(input int n);
        int r;
        r = n;
        if (r < 1) r = 1;
        if (r > 4) r = 4;
        return r;
    endfunction

    // digit store depth: two-digit mode always needs two entries
    function automatic int ssd_store_depth(input int n);
        int r;
        r = ssd_full_count(n);
        if (r < 2) r = 2;
        return r;
    endfunction

    // HGFEDCBA glyphs for 0..F
    function automatic logic [SEG_W-1:0] ssd_glyph(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] g;
        case (d)
            4'h0:    g = 8'h3F;
            4'h1:    g = 8'h06;
            4'h2:    g = 8'h5B;
            4'h3:    g = 8'h4F;
            4'h4:    g = 8'h66;
            4'h5:    g = 8'h6D;
            4'h6:    g = 8'h7D;
            4'h7:    g = 8'h07;
            4'h8:    g = 8'h7F;
            4'h9:    g = 8'h67;
            4'hA:    g = 8'h77;
            4'hB:    g = 8'h7C;
            4'hC:    g = 8'h39;
            4'hD:    g = 8'h5E;
            4'hE:    g = 8'h79;
            4'hF:    g = 8'h71;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/ssd_in_if.sv =====
// ----------------------------------------------------------------------------
// ssd_in_if
// input channel: display command and value with valid/ready
// ----------------------------------------------------------------------------
interface ssd_in_if
    import ssd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== rtl/ssd_out_if.sv =====
// ----------------------------------------------------------------------------
// ssd_out_if
// output channel: one digit result with valid/ready
// ----------------------------------------------------------------------------
interface ssd_out_if
    import ssd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] segments;
    logic [POS_W-1:0] digit_position;
    logic             last;

    modport source (output valid, output segments, output digit_position,
                    output last, input ready);
    modport sink   (input valid, input segments, input digit_position,
                    input last, output ready);
endinterface

// ===== rtl/ssd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssd_ctrl
// sequencer: runs the shared divider once per digit, then walks the digits
// most significant first into the output register
// ----------------------------------------------------------------------------
module ssd_ctrl
    import ssd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  ssd_stat_t           stat,
    output ssd_ctrl_t           ctrl,
    output logic [$clog2(ssd_store_depth(DIGIT_COUNT))-1:0] idx
);

    localparam int FULL  = ssd_full_count(DIGIT_COUNT);
    localparam int DEPTH = ssd_store_depth(DIGIT_COUNT);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int BIT_W = $clog2(VALUE_W);

    ssd_state_t       state_reg, state_next;
    logic [BIT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0] dig_cnt_reg, dig_cnt_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bit_cnt_reg  <= '0;
            dig_cnt_reg  <= '0;
            last_idx_reg <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            dig_cnt_reg  <= dig_cnt_next;
            last_idx_reg <= last_idx_next;
            pos_reg      <= pos_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        dig_cnt_next  = dig_cnt_reg;
        last_idx_next = last_idx_reg;
        pos_next      = pos_reg;
        in_ready      = 1'b0;
        ctrl          = '0;
        ctrl.pos      = pos_reg;
        ctrl.last     = (dig_cnt_reg == '0);
        idx           = dig_cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    // unused command is taken and dropped
                    case (cmd)
                        CMD_ONE:
                        begin
                            last_idx_next = '0;
                            pos_next      = POS_W'(FULL - 1);
                            ctrl.load     = 1'b1;
                        end
                        CMD_TWO:
                        begin
                            last_idx_next = IDX_W'(1);
                            pos_next      = '0;
                            ctrl.load     = 1'b1;
                        end
                        CMD_FULL:
                        begin
                            last_idx_next = IDX_W'(FULL - 1);
                            pos_next      = '0;
                            ctrl.load     = 1'b1;
                        end
                        default:
                        begin
                            ctrl.load = 1'b0;
                        end
                    endcase
                    if (ctrl.load)
                    begin
                        bit_cnt_next = '0;
                        dig_cnt_next = '0;
                        state_next   = ST_DIVIDE;
                    end
                end
            end

            ST_DIVIDE:
            begin
                ctrl.step    = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_W'(VALUE_W - 1))
                begin
                    ctrl.store = 1'b1;
                    // stop at the top digit and emit from there downward
                    if (dig_cnt_reg == last_idx_reg)
                        state_next = ST_EMIT;
                    else
                        dig_cnt_next = dig_cnt_reg + 1'b1;
                end
            end

            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctrl.emit = 1'b1;
                    pos_next  = pos_reg + 1'b1;
                    if (dig_cnt_reg == '0)
                        state_next = ST_IDLE;
                    else
                        dig_cnt_next = dig_cnt_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/ssd_dp.sv =====
// ----------------------------------------------------------------------------
// ssd_dp
// datapath: config registers, bit-serial restoring divider, digit store,
// glyph decode and output register
// ----------------------------------------------------------------------------
module ssd_dp
    import ssd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data,
    input  logic [VALUE_W-1:0]    value,
    input  ssd_ctrl_t             ctrl,
    input  logic [$clog2(ssd_store_depth(DIGIT_COUNT))-1:0] idx,
    output ssd_stat_t             stat,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [SEG_W-1:0]      segments,
    output logic [POS_W-1:0]      digit_position,
    output logic                  last
);

    localparam int DEPTH = ssd_store_depth(DIGIT_COUNT);

    logic [BASE_W-1:0]  base_reg;
    logic               anode_reg;
    logic [VALUE_W-1:0] dividend_reg, dividend_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [BASE_W-1:0]  trial;
    logic               fits;
    logic [DIGIT_W-1:0] digit_reg [DEPTH];
    logic               out_valid_reg;
    logic [SEG_W-1:0]   seg_reg, seg_next;
    logic [POS_W-1:0]   pos_reg;
    logic               last_reg;

    // configuration registers, out-of-range base writes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= BASE_RESET;
            anode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUMBER_BASE:
                begin
                    if (cfg_data >= BASE_MIN && cfg_data <= BASE_MAX)
                        base_reg <= cfg_data;
                end
                REG_COMMON_ANODE:
                begin
                    anode_reg <= cfg_data[0];
                end
                default:
                begin
                    anode_reg <= anode_reg;
                end
            endcase
        end
    end

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial         = {rem_reg, dividend_reg[VALUE_W-1]};
        fits          = (trial >= base_reg);
        rem_next      = fits ? DIGIT_W'(trial - base_reg) : trial[DIGIT_W-1:0];
        dividend_next = {dividend_reg[VALUE_W-2:0], fits};
    end

    // divider registers, quotient feeds the next digit
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dividend_reg <= value;
            rem_reg      <= '0;
        end
        else if (ctrl.step)
        begin
            dividend_reg <= dividend_next;
            rem_reg      <= ctrl.store ? '0 : rem_next;
        end
    end

    // digit store, least significant digit at entry 0
    always_ff @(posedge clk)
    begin
        if (ctrl.step && ctrl.store)
            digit_reg[idx] <= rem_next;
    end

    // glyph and polarity
    assign seg_next = ssd_glyph(digit_reg[idx]) ^ {SEG_W{anode_reg}};

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            seg_reg  <= seg_next;
            pos_reg  <= ctrl.pos;
            last_reg <= ctrl.last;
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign segments       = seg_reg;
    assign digit_position = pos_reg;
    assign last           = last_reg;

endmodule

// ===== rtl/seven_segment_base_digit_driver.sv =====
// operation: the shared bit-serial divider runs once per digit, then the digits
//   go into the output register, most significant first, as it frees up
// input: a new value is taken only once the last digit of the one before has
//   gone into the output register; cmd 3 is taken and dropped with no digits
// reset: base 10, common anode off, no result pending
// ----------------------------------------------------------------------------
// seven_segment_base_digit_driver
// splits a value into digits of a programmable base and emits one glyph
// item per digit, most significant first
// ----------------------------------------------------------------------------
module seven_segment_base_digit_driver
    import ssd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ssd_in_if.sink               number,
    ssd_out_if.source            display,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(ssd_store_depth(DIGIT_COUNT));

    ssd_ctrl_t        ctrl;
    ssd_stat_t        stat;
    logic [IDX_W-1:0] idx;

    // sequencer
    ssd_ctrl #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (number.valid),
        .in_ready (number.ready),
        .cmd      (number.cmd),
        .stat     (stat),
        .ctrl     (ctrl),
        .idx      (idx)
    );

    // divider, digit store and output register
    ssd_dp #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .value          (number.value),
        .ctrl           (ctrl),
        .idx            (idx),
        .stat           (stat),
        .out_ready      (display.ready),
        .out_valid      (display.valid),
        .segments       (display.segments),
        .digit_position (display.digit_position),
        .last           (display.last)
    );

endmodule

// ===== sim/tb_seven_segment_base_digit_driver.sv =====
// ----------------------------------------------------------------------------
// tb_seven_segment_base_digit_driver
// Drives display values through the digit driver under several radix and
// polarity settings. A scoreboard predicts every glyph item from its own copy
// of the registers and compares each returned item field by field. Both
// channels idle at random, and one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
module tb_seven_segment_base_digit_driver;
    timeunit 1ns;
    timeprecision 1ps;

    import ssd_pkg::*;

    localparam int DIGITS         = 4;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 40;

    // unused command, produces no digits
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [POS_W-1:0] position;
        logic             last;
    } digit_item_t;

    // expected glyph items and a private copy of the display registers
    class digit_scoreboard;
        digit_item_t pending_q[$];
        int unsigned radix;
        bit          invert;
        int unsigned shown;
        int          errors;
        int          checked;
        int          writes;
        int          cmd_count[4];

        function new(int digits);
            radix   = 10;
            invert  = 0;
            shown   = (digits < 1) ? 1 : ((digits > 4) ? 4 : digits);
            errors  = 0;
            checked = 0;
            writes  = 0;
            foreach (cmd_count[i])
                cmd_count[i] = 0;
        endfunction

        // register write as seen by the block
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            writes++;
            if (idx == REG_NUMBER_BASE)
            begin
                if (data >= BASE_MIN && data <= BASE_MAX)
                    radix = data;
            end
            else
                invert = data[0];
        endfunction

        // HGFEDCBA patterns for hex digits
        function logic [SEG_W-1:0] glyph(int unsigned d);
            logic [SEG_W-1:0] g;
            case (d)
                0:       g = 8'b0011_1111;
                1:       g = 8'b0000_0110;
                2:       g = 8'b0101_1011;
                3:       g = 8'b0100_1111;
                4:       g = 8'b0110_0110;
                5:       g = 8'b0110_1101;
                6:       g = 8'b0111_1101;
                7:       g = 8'b0000_0111;
                8:       g = 8'b0111_1111;
                9:       g = 8'b0110_0111;
                10:      g = 8'b0111_0111;
                11:      g = 8'b0111_1100;
                12:      g = 8'b0011_1001;
                13:      g = 8'b0101_1110;
                14:      g = 8'b0111_1001;
                default: g = 8'b0111_0001;
            endcase
            return g;
        endfunction

        // glyph of digit k, counted from the least significant one
        function logic [SEG_W-1:0] digit_glyph(logic [VALUE_W-1:0] v, int unsigned k);
            int unsigned      q;
            logic [SEG_W-1:0] g;
            q = v;
            repeat (k)
                q = q / radix;
            g = glyph(q % radix);
            return invert ? ~g : g;
        endfunction

        function void push(logic [SEG_W-1:0] seg, int unsigned pos, bit last);
            digit_item_t e;
            e.segments = seg;
            e.position = pos[POS_W-1:0];
            e.last     = last;
            pending_q.push_back(e);
        endfunction

        // accepted value: queue its digits, most significant first
        function void note_value(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] v);
            cmd_count[cmd]++;
            case (cmd)
                CMD_ONE:
                    push(digit_glyph(v, 0), shown - 1, 1);
                CMD_TWO:
                begin
                    push(digit_glyph(v, 1), 0, 0);
                    push(digit_glyph(v, 0), 1, 1);
                end
                CMD_FULL:
                    for (int unsigned p = 0; p < shown; p++)
                        push(digit_glyph(v, shown - 1 - p), p, p == shown - 1);
                default:
                    ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("[%0t] ERROR: %s", $realtime, msg);
        endtask

        // accepted glyph item against the oldest prediction
        task check_digit(logic [SEG_W-1:0] seg, logic [POS_W-1:0] pos, logic last);
            digit_item_t e;
            checked++;
            if (pending_q.size() == 0)
                report($sformatf("unexpected digit item seg=%h pos=%0d last=%0b",
                                 seg, pos, last));
            else
            begin
                e = pending_q.pop_front();
                if (seg !== e.segments)
                    report($sformatf("segments %h, predicted %h (pos %0d)",
                                     seg, e.segments, e.position));
                if (pos !== e.position)
                    report($sformatf("digit_position %0d, predicted %0d",
                                     pos, e.position));
                if (last !== e.last)
                    report($sformatf("last %0b, predicted %0b (pos %0d)",
                                     last, e.last, e.position));
            end
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    ssd_in_if  in_ch ();
    ssd_out_if out_ch ();

    digit_scoreboard sb;

    // stimulus controls shared with the receiver
    bit tx_gaps   = 1'b1;
    bit rx_stalls = 1'b1;
    bit hold_req  = 1'b0;
    bit holding   = 1'b0;

    seven_segment_base_digit_driver #(
        .DIGIT_COUNT (DIGITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .number    (in_ch),
        .display   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always #5 clk = ~clk;

    // input monitor
    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            sb.note_value(in_ch.cmd, in_ch.value);
    end

    // output monitor
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
            sb.check_digit(out_ch.segments, out_ch.digit_position, out_ch.last);
    end

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                holding = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holding  = 1'b0;
            end
            else if (rx_stalls && $urandom_range(0, 2) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat (rx_stalls ? $urandom_range(1, 12) : 1) @(posedge clk);
            end
        end
    end

    // watchdog: cycles with no item accepted on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] ERROR: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // one value item, with an optional idle burst in front
    task send_value(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] v);
        if (tx_gaps && $urandom_range(0, 2) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= cmd;
        in_ch.value <= v;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // mixed random item, biased toward the value extremes
    task send_random;
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] v;
        int                 pick;
        pick = $urandom_range(0, 9);
        cmd  = (pick < 3) ? CMD_ONE : (pick < 6) ? CMD_TWO : (pick < 9) ? CMD_FULL : CMD_NONE;
        case ($urandom_range(0, 7))
            0:       v = '1;
            1:       v = '0;
            2:       v = VALUE_W'($urandom_range(0, 255));
            default: v = VALUE_W'($urandom);
        endcase
        send_value(cmd, v);
    endtask

    // stop sending, wait out every predicted digit and the divider
    task drain;
        in_ch.valid <= 1'b0;
        // let the input monitor note an item accepted at this edge
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // idle the block, then write both registers
    task configure(logic [CFG_DAT_W-1:0] radix_data, bit invert);
        drain;
        write_reg(REG_NUMBER_BASE, radix_data);
        write_reg(REG_COMMON_ANODE, {(CFG_DAT_W-1)'($urandom_range(0, 15)), invert});
        cfg_we <= 1'b0;
    endtask

    // main sequence
    initial
    begin
        int phase_radix[6];
        sb = new(DIGITS);
        phase_radix = '{7, 16, 1, 2, 31, 13};

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_NUMBER_BASE;
        cfg_data     <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.cmd    <= CMD_ONE;
        in_ch.value  <= '0;
        out_ch.ready <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: decimal, common cathode
        send_value(CMD_ONE,  16'd0);
        send_value(CMD_ONE,  16'hFFFF);
        send_value(CMD_TWO,  16'd0);
        send_value(CMD_TWO,  16'hFFFF);
        send_value(CMD_FULL, 16'd0);
        send_value(CMD_FULL, 16'hFFFF);
        send_value(CMD_FULL, 16'd1234);
        send_value(CMD_NONE, 16'hFFFF);

        // hex, inverted segments
        configure(5'd16, 1'b1);
        send_value(CMD_FULL, 16'hFFFF);
        send_value(CMD_FULL, 16'h0123);
        send_value(CMD_TWO,  16'hABCD);
        send_value(CMD_ONE,  16'hFEDC);

        // binary, upper digits wrap
        configure(5'd2, 1'b0);
        send_value(CMD_FULL, 16'hFFFF);
        send_value(CMD_FULL, 16'h0000);
        send_value(CMD_ONE,  16'h0001);
        send_value(CMD_TWO,  16'h5555);

        // rejected radix writes keep binary
        configure(5'd0, 1'b1);
        send_value(CMD_FULL, 16'h000A);
        configure(5'd17, 1'b0);
        send_value(CMD_FULL, 16'h0009);
        send_value(CMD_TWO,  16'h0003);

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++)
        begin
            configure(CFG_DAT_W'(phase_radix[ph]), 1'($urandom_range(0, 1)));
            repeat (28)
                send_random;
            if (ph == 3)
            begin
                // long receiver hold-off while the sender keeps pushing
                hold_req = 1'b1;
                wait (holding);
                tx_gaps = 1'b0;
                repeat (16)
                    send_random;
                tx_gaps = 1'b1;
                drain;
            end
        end

        // last part: no idling on either side
        configure(CFG_DAT_W'($urandom_range(3, 15)), 1'($urandom_range(0, 1)));
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        repeat (20)
            send_random;
        drain;

        if (sb.pending_q.size() != 0)
            sb.report($sformatf("%0d predicted digit items never arrived",
                                sb.pending_q.size()));

        $display("run: %0d values (one %0d, two %0d, full %0d, unused %0d), %0d digits checked",
                 sb.cmd_count[0] + sb.cmd_count[1] + sb.cmd_count[2] + sb.cmd_count[3],
                 sb.cmd_count[0], sb.cmd_count[1], sb.cmd_count[2], sb.cmd_count[3],
                 sb.checked);
        $display("run: %0d register writes, radix 2 to 16 with rejected writes, both polarities",
                 sb.writes);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
